// ===== hw/rtl/threshold_anomaly_monitor_defines.svh =====
// Assertion macros shared by the threshold anomaly monitor RTL.
// Every macro expects clk_i and rst_ni in the scope where it is used.
`ifndef THRESHOLD_ANOMALY_MONITOR_DEFINES_SVH
`define THRESHOLD_ANOMALY_MONITOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TAM_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TAM_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tam_pkg.sv =====
// Types and constants of the threshold anomaly monitor.
// No dependencies; the regs, intake, rules and top-level files import it.
package tam_pkg;

  localparam int unsigned TimeW     = 63;
  localparam int unsigned CpuW      = 13;
  localparam int unsigned WsW       = 48;
  localparam int unsigned DiskW     = 64;
  localparam int unsigned LatW      = 32;
  localparam int unsigned ProgW     = 17;
  localparam int unsigned RunW      = 8;
  localparam int unsigned StallLimW = 16;
  localparam int unsigned StallMsW  = 26;
  localparam int unsigned ApbAddrW  = 6;
  localparam int unsigned ApbDataW  = 64;

  localparam logic [ProgW-1:0] ProgressTolerance = 17'd10;
  localparam logic [9:0]       MsPerSecond       = 10'd1000;

  localparam logic [CpuW-1:0]      CpuLimitReset   = 13'd900;
  localparam logic [RunW-1:0]      CpuRunReset     = 8'd3;
  localparam logic [WsW-1:0]       MemLimitReset   = 48'd2147483648;
  localparam logic [DiskW-1:0]     DiskLimitReset  = 64'd104857600;
  localparam logic [LatW-1:0]      LatLimitReset   = 32'd1000;
  localparam logic [StallLimW-1:0] StallLimitReset = 16'd60;

  typedef enum logic [2:0] {
    REG_CPU_LIMIT      = 3'd0,
    REG_CPU_RUN_NEEDED = 3'd1,
    REG_MEMORY_LIMIT   = 3'd2,
    REG_DISK_LIMIT     = 3'd3,
    REG_LATENCY_LIMIT  = 3'd4,
    REG_STALL_LIMIT    = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [CpuW-1:0]      cpu_limit_tenths;
    logic [RunW-1:0]      cpu_run_needed;
    logic [WsW-1:0]       memory_limit_bytes;
    logic [DiskW-1:0]     disk_limit_bytes;
    logic [LatW-1:0]      latency_limit_ms;
    logic [StallLimW-1:0] stall_limit_seconds;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] sample_time_ms;
    logic [CpuW-1:0]  cpu_tenths;
    logic [WsW-1:0]   working_set_bytes;
    logic [DiskW-1:0] disk_read_total;
    logic [DiskW-1:0] disk_write_total;
    logic             server_up;
    logic [LatW-1:0]  lat_ms;
    logic             job_running;
    logic             progress_known;
    logic [ProgW-1:0] progress_milli;
  } sample_t;

  typedef struct packed {
    logic             sample_checked;
    logic             cpu_alarm;
    logic             mem_alarm;
    logic             disk_spike;
    logic             server_down;
    logic             latency_high;
    logic             stall_alarm;
    logic [RunW-1:0]  cpu_run;
    logic [DiskW-1:0] disk_delta_bytes;
    logic [TimeW-1:0] stalled_ms;
  } flags_t;

  // A sample after intake: the skip decision and the clamped disk growth
  // are already resolved against the previous sample.
  typedef struct packed {
    logic             checked;
    logic [TimeW-1:0] sample_time_ms;
    logic [CpuW-1:0]  cpu_tenths;
    logic [WsW-1:0]   working_set_bytes;
    logic [DiskW-1:0] read_growth;
    logic [DiskW-1:0] write_growth;
    logic             server_up;
    logic [LatW-1:0]  lat_ms;
    logic             job_running;
    logic             progress_known;
    logic [ProgW-1:0] progress_milli;
  } intake_t;

endpackage

// ===== hw/rtl/tam_stream_if.sv =====
// Valid/ready stream channel used for samples and flag words.
// The payload type is set per instance; depends on nothing else.
interface tam_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/tam_regs.sv =====
// APB configuration registers of the threshold anomaly monitor.
// Depends on tam_pkg for the register map and the reset values.
module tam_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tam_pkg::ApbAddrW-1:0]  paddr,
  input  logic [tam_pkg::ApbDataW-1:0]  pwdata,
  output logic [tam_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output tam_pkg::cfg_t                 cfg_o
);
  import tam_pkg::*;

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  // Registers sit on 8-byte boundaries; the low address bits are ignored.
  assign idx    = reg_idx_e'(paddr[ApbAddrW-1:3]);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cpu_limit_tenths    <= CpuLimitReset;
      cfg_q.cpu_run_needed      <= CpuRunReset;
      cfg_q.memory_limit_bytes  <= MemLimitReset;
      cfg_q.disk_limit_bytes    <= DiskLimitReset;
      cfg_q.latency_limit_ms    <= LatLimitReset;
      cfg_q.stall_limit_seconds <= StallLimitReset;
    end else if (wr_en) begin
      case (idx)
        REG_CPU_LIMIT:      cfg_q.cpu_limit_tenths    <= pwdata[CpuW-1:0];
        REG_CPU_RUN_NEEDED: cfg_q.cpu_run_needed      <= pwdata[RunW-1:0];
        REG_MEMORY_LIMIT:   cfg_q.memory_limit_bytes  <= pwdata[WsW-1:0];
        REG_DISK_LIMIT:     cfg_q.disk_limit_bytes    <= pwdata[DiskW-1:0];
        REG_LATENCY_LIMIT:  cfg_q.latency_limit_ms    <= pwdata[LatW-1:0];
        REG_STALL_LIMIT:    cfg_q.stall_limit_seconds <= pwdata[StallLimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CPU_LIMIT:      prdata = ApbDataW'(cfg_q.cpu_limit_tenths);
      REG_CPU_RUN_NEEDED: prdata = ApbDataW'(cfg_q.cpu_run_needed);
      REG_MEMORY_LIMIT:   prdata = ApbDataW'(cfg_q.memory_limit_bytes);
      REG_DISK_LIMIT:     prdata = ApbDataW'(cfg_q.disk_limit_bytes);
      REG_LATENCY_LIMIT:  prdata = ApbDataW'(cfg_q.latency_limit_ms);
      REG_STALL_LIMIT:    prdata = ApbDataW'(cfg_q.stall_limit_seconds);
      default:            prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/tam_intake.sv =====
// Input register of the monitor: takes a sample request, decides whether it
// is checked and computes the clamped disk growth. Depends on tam_pkg and tam_stream_if.
module tam_intake (
  input  logic             clk_i,
  input  logic             rst_ni,
  tam_stream_if.sink       sample_i,
  output tam_pkg::intake_t item_o,
  output logic             valid_o,
  input  logic             ready_i
);
  import tam_pkg::*;

  sample_t          s;
  intake_t          item_d;
  intake_t          item_q;
  logic             valid_q;
  logic             prev_valid_q;
  logic [DiskW-1:0] prev_read_q;
  logic [DiskW-1:0] prev_write_q;
  logic [DiskW:0]   read_diff;
  logic [DiskW:0]   write_diff;
  logic             accept;

  assign s              = sample_i.payload;
  assign sample_i.ready = !valid_q || ready_i;
  assign accept         = sample_i.valid && sample_i.ready;

  // The borrow bit of each difference means the counter went backwards.
  assign read_diff  = {1'b0, s.disk_read_total} - {1'b0, prev_read_q};
  assign write_diff = {1'b0, s.disk_write_total} - {1'b0, prev_write_q};

  always_comb begin
    item_d.checked           = (s.sample_time_ms != '0) && prev_valid_q;
    item_d.sample_time_ms    = s.sample_time_ms;
    item_d.cpu_tenths        = s.cpu_tenths;
    item_d.working_set_bytes = s.working_set_bytes;
    item_d.read_growth       = read_diff[DiskW] ? '0 : read_diff[DiskW-1:0];
    item_d.write_growth      = write_diff[DiskW] ? '0 : write_diff[DiskW-1:0];
    item_d.server_up         = s.server_up;
    item_d.lat_ms            = s.lat_ms;
    item_d.job_running       = s.job_running;
    item_d.progress_known    = s.progress_known;
    item_d.progress_milli    = s.progress_milli;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      prev_valid_q <= 1'b0;
    end else if (accept) begin
      valid_q      <= 1'b1;
      prev_valid_q <= s.sample_time_ms != '0;
    end else if (ready_i) begin
      valid_q      <= 1'b0;
    end
  end

  // Previous totals are only read while prev_valid_q is set.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q       <= item_d;
      prev_read_q  <= s.disk_read_total;
      prev_write_q <= s.disk_write_total;
    end
  end

  assign item_o  = item_q;
  assign valid_o = valid_q;

endmodule

// ===== hw/rtl/tam_rules.sv =====
// Rule evaluation and result register: CPU run counter, stall tracker and
// the threshold compares. Depends on tam_pkg, tam_stream_if and the defines.
module tam_rules (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tam_pkg::cfg_t    cfg_i,
  input  tam_pkg::intake_t item_i,
  input  logic             valid_i,
  output logic             ready_o,
  tam_stream_if.source     flags_o
);
  import tam_pkg::*;
  `include "threshold_anomaly_monitor_defines.svh"

  logic [RunW-1:0]     cpu_run_q;
  logic                tracking_q;
  logic [ProgW-1:0]    last_prog_q;
  logic [TimeW-1:0]    last_change_q;
  logic                alerted_q;
  flags_t              flags_d;
  flags_t              flags_q;
  logic                out_valid_q;

  logic                advance;
  logic                update;
  logic                cpu_over;
  logic [RunW-1:0]     run_inc;
  logic [RunW-1:0]     run_new;
  logic                stall_on;
  logic [ProgW-1:0]    prog_diff;
  logic                rebase;
  logic [TimeW-1:0]    base_time;
  logic                alerted_base;
  logic [TimeW:0]      elapsed;
  logic                behind;
  logic [TimeW-1:0]    stalled;
  logic [StallMsW-1:0] stall_ms_limit;
  logic                stall_hit;
  logic [DiskW:0]      disk_sum;
  logic [DiskW-1:0]    disk_delta;

  assign ready_o = !out_valid_q || flags_o.ready;
  assign advance = valid_i && ready_o;
  assign update  = advance && item_i.checked;

  assign cpu_over = item_i.cpu_tenths > cfg_i.cpu_limit_tenths;
  assign run_inc  = (cpu_run_q == '1) ? cpu_run_q : cpu_run_q + 1'b1;
  assign run_new  = cpu_over ? run_inc : '0;

  assign stall_on = (cfg_i.stall_limit_seconds != '0) && item_i.server_up &&
                    item_i.job_running && item_i.progress_known;
  assign prog_diff = (item_i.progress_milli > last_prog_q) ?
                     item_i.progress_milli - last_prog_q :
                     last_prog_q - item_i.progress_milli;
  // A fresh tracker or a real progress change restarts the stall clock.
  assign rebase       = !tracking_q || (prog_diff > ProgressTolerance);
  assign base_time    = rebase ? item_i.sample_time_ms : last_change_q;
  assign alerted_base = rebase ? 1'b0 : alerted_q;

  assign elapsed = {1'b0, item_i.sample_time_ms} - {1'b0, base_time};
  assign behind  = elapsed[TimeW];
  assign stalled = (stall_on && !behind) ? elapsed[TimeW-1:0] : '0;
  assign stall_ms_limit = StallMsW'(cfg_i.stall_limit_seconds) *
                          StallMsW'(MsPerSecond);
  assign stall_hit = stall_on && !alerted_base && !behind &&
                     (stalled >= TimeW'(stall_ms_limit));

  assign disk_sum   = {1'b0, item_i.read_growth} + {1'b0, item_i.write_growth};
  assign disk_delta = disk_sum[DiskW] ? '1 : disk_sum[DiskW-1:0];

  always_comb begin
    flags_d = '0;
    if (item_i.checked) begin
      flags_d.sample_checked   = 1'b1;
      // With the CPU over its limit the run is at least one, so a needed
      // count of zero acts as one without a separate check.
      flags_d.cpu_alarm        = cpu_over && (run_new >= cfg_i.cpu_run_needed);
      flags_d.mem_alarm        = item_i.working_set_bytes > cfg_i.memory_limit_bytes;
      flags_d.disk_spike       = disk_delta > cfg_i.disk_limit_bytes;
      flags_d.server_down      = !item_i.server_up;
      flags_d.latency_high     = item_i.server_up &&
                                 (item_i.lat_ms > cfg_i.latency_limit_ms);
      flags_d.stall_alarm      = stall_hit;
      flags_d.cpu_run          = run_new;
      flags_d.disk_delta_bytes = disk_delta;
      flags_d.stalled_ms       = stalled;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_run_q     <= '0;
      tracking_q    <= 1'b0;
      last_prog_q   <= '0;
      last_change_q <= '0;
      alerted_q     <= 1'b0;
    end else if (update) begin
      cpu_run_q <= run_new;
      if (stall_on) begin
        tracking_q    <= 1'b1;
        last_prog_q   <= rebase ? item_i.progress_milli : last_prog_q;
        last_change_q <= base_time;
        alerted_q     <= alerted_base || stall_hit;
      end else begin
        tracking_q    <= 1'b0;
        last_prog_q   <= '0;
        last_change_q <= '0;
        alerted_q     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (flags_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      flags_q <= flags_d;
    end
  end

  assign flags_o.valid   = out_valid_q;
  assign flags_o.payload = flags_q;

  `TAM_CHECK(a_skipped_all_zero, out_valid_q && !flags_q.sample_checked, flags_q == '0, "skipped sample carries nonzero flags")
  `TAM_CHECK(a_cpu_flag_has_run, out_valid_q && flags_q.cpu_alarm, flags_q.cpu_run != '0, "CPU flag with an empty run count")
  `TAM_CHECK(a_stall_min_time, out_valid_q && flags_q.stall_alarm, flags_q.stalled_ms >= TimeW'(MsPerSecond), "stall flag below one second")
  `TAM_CHECK(a_idle_tracker_clear, !tracking_q, (last_change_q == '0) && (last_prog_q == '0) && !alerted_q, "stall tracker state left over while idle")
  `TAM_CHECK_NEXT(a_state_hold, !update, $stable(cpu_run_q) && $stable(tracking_q) && $stable(last_change_q), "rule state moved without a checked sample")

endmodule

// ===== hw/rtl/threshold_anomaly_monitor.sv =====
// Threshold anomaly monitor: one flag word per monitoring sample request.
// A sample is accepted in every cycle the result side keeps up; its flag
// word is formed in the intake register (skip decision, disk growth) and
// then the result register (CPU run, stall tracker, threshold compares),
// and offered from the latter. Each stage holds one request and passes
// ready back combinationally, so a flag word the receiver does not take
// stalls the rule stage at once and the input one sample later; at most two
// samples are in flight. Registers are written and read over APB at byte
// address 8 * index; reset needs no clearing time. Depends on tam_pkg,
// tam_stream_if, tam_regs, tam_intake and tam_rules.
module threshold_anomaly_monitor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tam_stream_if.sink                    sample_i,
  tam_stream_if.source                  flags_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tam_pkg::ApbAddrW-1:0]  paddr,
  input  logic [tam_pkg::ApbDataW-1:0]  pwdata,
  output logic [tam_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import tam_pkg::*;

  cfg_t    cfg;
  intake_t item;
  logic    item_valid;
  logic    item_ready;

  tam_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tam_intake u_intake (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_i),
    .item_o   (item),
    .valid_o  (item_valid),
    .ready_i  (item_ready)
  );

  tam_rules u_rules (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .item_i  (item),
    .valid_i (item_valid),
    .ready_o (item_ready),
    .flags_o (flags_o)
  );

endmodule
